// File: hw/rtl/b64c_pkg.sv
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, constants and alphabet lookups for the base64 codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

    // Permuted alphabet; character for sextet i sits at byte 63-i.
    localparam logic [63:0][7:0] ALPHABET =
        "LZp8yQ0+E57T1ciArhYSkGjK94Psbn/udeRxo6tf3UCXHzNlvMIBOqaVgJw2mWFD";

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam int         NUM_RES    = 4;
    localparam int         RES_CNT_W  = 3;
    localparam int         RES_IDX_W  = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } b64c_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       bad_char;
    } b64c_out_t;

    // Results caused by one input transaction, in emission order.
    typedef struct packed {
        logic [RES_CNT_W-1:0]        count;
        b64c_out_t [NUM_RES-1:0]     items;
    } b64c_batch_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] value;
    } b64c_sextet_t;

    function automatic logic [7:0] alpha_char(input logic [5:0] sextet);
        return ALPHABET[6'd63 - sextet];
    endfunction

    function automatic b64c_sextet_t sextet_of(input logic [7:0] code);
        b64c_sextet_t r;
        r.hit   = 1'b0;
        r.value = '0;
        for (int i = 0; i < 64; i++) begin
            if (ALPHABET[63 - i] == code) begin
                r.hit   = 1'b1;
                r.value = 6'(i);
            end
        end
        return r;
    endfunction

    function automatic b64c_out_t mk_res(input logic [7:0] val, input logic last,
                                         input logic bad);
        b64c_out_t r;
        r.out_byte = val;
        r.out_last = last;
        r.bad_char = bad;
        return r;
    endfunction

endpackage

// File: hw/rtl/b64c_core.sv
// ----------------------------------------------------------------------------
// b64c_core
// Input register, group state and single-pass encode/decode of one item.
// ----------------------------------------------------------------------------
module b64c_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  b64c_pkg::b64c_in_t    s_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  buf_free,
    output logic                  batch_valid,
    output b64c_pkg::b64c_batch_t batch
);
    import b64c_pkg::*;

    logic          in_valid_reg;
    b64c_in_t      in_reg;
    logic          dir_reg;
    logic [17:0]   bits_reg;
    logic [17:0]   bits_next;
    logic [1:0]    fill_reg;
    logic [1:0]    fill_next;
    logic          fire;

    logic [17:0]   gb;
    logic [1:0]    fill_n;
    logic [23:0]   word;
    logic          tail;
    b64c_sextet_t  lk;

    assign fire        = in_valid_reg && buf_free;
    assign s_ready     = !in_valid_reg || fire;
    assign cfg_ready   = 1'b1;
    assign batch_valid = fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg  <= 1'b0;
            bits_reg <= '0;
            fill_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            // a direction write starts a fresh group
            dir_reg  <= cfg_data;
            bits_reg <= '0;
            fill_reg <= '0;
        end else if (fire) begin
            bits_reg <= bits_next;
            fill_reg <= fill_next;
        end
    end

    always_comb begin
        batch     = '0;
        bits_next = bits_reg;
        fill_next = fill_reg;
        gb        = bits_reg;
        fill_n    = fill_reg;
        word      = '0;
        tail      = 1'b0;
        lk        = sextet_of(in_reg.in_byte);

        if (!dir_reg) begin
            if (fill_reg >= 2'd2) begin
                word = {bits_reg[15:0], in_reg.in_byte};
                batch.items[0] = mk_res(alpha_char(word[23:18]), 1'b0, 1'b0);
                batch.items[1] = mk_res(alpha_char(word[17:12]), 1'b0, 1'b0);
                batch.items[2] = mk_res(alpha_char(word[11:6]), 1'b0, 1'b0);
                batch.items[3] = mk_res(alpha_char(word[5:0]), in_reg.in_last, 1'b0);
                batch.count    = RES_CNT_W'(4);
                bits_next      = '0;
                fill_next      = '0;
            end else begin
                gb     = {bits_reg[9:0], in_reg.in_byte};
                fill_n = fill_reg + 2'd1;
                if (in_reg.in_last) begin
                    if (fill_n == 2'd1) begin
                        batch.items[0] = mk_res(alpha_char(gb[7:2]), 1'b0, 1'b0);
                        batch.items[1] = mk_res(alpha_char({gb[1:0], 4'b0}), 1'b0, 1'b0);
                        batch.items[2] = mk_res(PAD_CHAR, 1'b0, 1'b0);
                    end else begin
                        batch.items[0] = mk_res(alpha_char(gb[15:10]), 1'b0, 1'b0);
                        batch.items[1] = mk_res(alpha_char(gb[9:4]), 1'b0, 1'b0);
                        batch.items[2] = mk_res(alpha_char({gb[3:0], 2'b0}), 1'b0, 1'b0);
                    end
                    batch.items[3] = mk_res(PAD_CHAR, 1'b1, 1'b0);
                    batch.count    = RES_CNT_W'(4);
                    bits_next      = '0;
                    fill_next      = '0;
                end else begin
                    bits_next = gb;
                    fill_next = fill_n;
                end
            end
        end else begin
            if (in_reg.in_byte == PAD_CHAR) begin
                // padding carries no bits; the group goes on
                tail = 1'b1;
            end else if (!lk.hit) begin
                batch.items[0] = mk_res(8'h00, in_reg.in_last, 1'b1);
                batch.count    = RES_CNT_W'(1);
                bits_next      = '0;
                fill_next      = '0;
            end else if (fill_reg == 2'd3) begin
                word = {bits_reg, lk.value};
                batch.items[0] = mk_res(word[23:16], 1'b0, 1'b0);
                batch.items[1] = mk_res(word[15:8], 1'b0, 1'b0);
                batch.items[2] = mk_res(word[7:0], in_reg.in_last, 1'b0);
                batch.count    = RES_CNT_W'(3);
                bits_next      = '0;
                fill_next      = '0;
            end else begin
                gb     = {bits_reg[11:0], lk.value};
                fill_n = fill_reg + 2'd1;
                tail   = 1'b1;
            end

            if (tail) begin
                if (in_reg.in_last) begin
                    unique case (fill_n)
                        2'd1: begin
                            batch.items[0] = mk_res(8'h00, 1'b1, 1'b1);
                            batch.count    = RES_CNT_W'(1);
                        end
                        2'd2: begin
                            batch.items[0] = mk_res(gb[11:4], 1'b1, 1'b0);
                            batch.count    = RES_CNT_W'(1);
                        end
                        2'd3: begin
                            batch.items[0] = mk_res(gb[17:10], 1'b0, 1'b0);
                            batch.items[1] = mk_res(gb[9:2], 1'b1, 1'b0);
                            batch.count    = RES_CNT_W'(2);
                        end
                        default: begin
                            batch.count = '0;
                        end
                    endcase
                    bits_next = '0;
                    fill_next = '0;
                end else begin
                    bits_next = gb;
                    fill_next = fill_n;
                end
            end
        end
    end

endmodule

// File: hw/rtl/b64c_outq.sv
// ----------------------------------------------------------------------------
// b64c_outq
// Result buffer: holds the results of one transaction and sends them in order.
// ----------------------------------------------------------------------------
module b64c_outq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  batch_valid,
    input  b64c_pkg::b64c_batch_t batch,
    output logic                  buf_free,
    output logic                  m_valid,
    input  logic                  m_ready,
    output b64c_pkg::b64c_out_t   m_data
);
    import b64c_pkg::*;

    b64c_out_t [NUM_RES-1:0] items_reg;
    logic [RES_CNT_W-1:0]    rem_reg;
    logic [RES_CNT_W-1:0]    rem_next;
    logic [RES_IDX_W-1:0]    rd_reg;
    logic [RES_IDX_W-1:0]    rd_next;
    logic                    load;
    logic                    take;

    assign m_valid  = (rem_reg != '0);
    assign take     = m_valid && m_ready;
    // free once the last held result leaves this cycle
    assign buf_free = (rem_reg == '0) || (rem_reg == RES_CNT_W'(1) && m_ready);
    assign load     = batch_valid && (batch.count != '0);
    assign m_data   = items_reg[rd_reg];

    always_comb begin
        rem_next = rem_reg;
        rd_next  = rd_reg;
        if (load) begin
            rem_next = batch.count;
            rd_next  = '0;
        end else if (take) begin
            rem_next = rem_reg - RES_CNT_W'(1);
            rd_next  = rd_reg + RES_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            rd_reg  <= '0;
        end else begin
            rem_reg <= rem_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            items_reg <= batch.items;
        end
    end

endmodule

// File: hw/rtl/base64_codec_custom_alphabet_top.sv
// ----------------------------------------------------------------------------
// base64_codec_custom_alphabet_top
// Streaming base64 encoder/decoder over a fixed permuted alphabet.
//
// An input transaction is registered, processed in one pass against the
// group state and its results (up to four) are loaded into a result buffer
// that sends one result per cycle on the m_ channel while m_ready is high.
// The registered item is processed only when the buffer is empty or about to
// send its last result; this holds for items that cause no result too. With
// the buffer empty, items that cause no result stream at one per cycle. An
// item that causes k results occupies the buffer until its last result is
// taken, and the items behind it wait for that. Encoding therefore
// alternates the four results of a group with the bytes that waited behind
// them; decoding alternates three results with the characters that waited.
// The first result is presented once the registered item has been processed
// and its results loaded into the result buffer. Write direction
// (0 encode, 1 decode) only while idle; a write clears the partial group.
// ----------------------------------------------------------------------------
module base64_codec_custom_alphabet_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64c_pkg::b64c_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b64c_pkg::b64c_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import b64c_pkg::*;

    logic        buf_free;
    logic        batch_valid;
    b64c_batch_t batch;

    b64c_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .buf_free    (buf_free),
        .batch_valid (batch_valid),
        .batch       (batch)
    );

    b64c_outq u_outq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .batch_valid (batch_valid),
        .batch       (batch),
        .buf_free    (buf_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // a flagged result never carries data
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_char |-> m_data.out_byte == 8'h00)
        else $error("bad_char result with nonzero byte");

    // input stalls only behind pending results
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with result buffer empty");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !m_valid)
        else $error("result pending after reset");

    // a new batch never lands on unsent results
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        batch_valid && batch.count != '0 && m_valid |-> m_ready)
        else $error("result buffer overwritten");

endmodule

// File: tb/base64_codec_custom_alphabet_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_codec_custom_alphabet_top_tb
// Self-checking bench for the base64 codec with the permuted alphabet.
// A queue-fed driver pushes bytes or characters with random gaps. A result
// sink applies random backpressure and checks each result against a
// bit-accurate codec predictor that runs on accepted transactions. The
// direction is switched between phases, always while the codec is idle.
// ----------------------------------------------------------------------------
module base64_codec_custom_alphabet_top_tb;
    import b64c_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_REPORTS  = 10;
    localparam bit DIR_ENCODE   = 1'b0;
    localparam bit DIR_DECODE   = 1'b1;

    // Entry i is the character for sextet i.
    localparam logic [0:63][7:0] CHARSET =
        "LZp8yQ0+E57T1ciArhYSkGjK94Psbn/udeRxo6tf3UCXHzNlvMIBOqaVgJw2mWFD";

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    b64c_in_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    b64c_out_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;

    b64c_in_t  byte_q[$];
    b64c_out_t expected_q[$];
    int        fault_count  = 0;
    int        quiet_cycles = 0;
    int        s_gap        = 0;
    bit        s_burst      = 1'b0;
    int        m_hold       = 0;
    bit        m_burst      = 1'b0;

    // Predicted codec state
    bit        codec_dir;
    bit [17:0] grp_bits;
    int        grp_fill;
    int        pad_seen;

    base64_codec_custom_alphabet_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic void clear_group();
        grp_bits = '0;
        grp_fill = 0;
        pad_seen = 0;
    endfunction

    function automatic void push_result(input logic [7:0] val, input logic last,
                                        input logic bad);
        b64c_out_t r;
        r.out_byte = val;
        r.out_last = last;
        r.bad_char = bad;
        expected_q.push_back(r);
    endfunction

    function automatic int sextet_index(input logic [7:0] code);
        for (int i = 0; i < 64; i++) begin
            if (CHARSET[i] == code) return i;
        end
        return -1;
    endfunction

    // Advance the predicted codec by one accepted transaction.
    function automatic void codec_step(input b64c_in_t it);
        logic [23:0] word;
        int          sx;
        if (codec_dir == DIR_ENCODE) begin
            if (grp_fill >= 2) begin
                word = {grp_bits[15:0], it.in_byte};
                push_result(CHARSET[word[23:18]], 1'b0, 1'b0);
                push_result(CHARSET[word[17:12]], 1'b0, 1'b0);
                push_result(CHARSET[word[11:6]], 1'b0, 1'b0);
                push_result(CHARSET[word[5:0]], it.in_last, 1'b0);
                clear_group();
            end else begin
                grp_bits = {grp_bits[9:0], it.in_byte};
                grp_fill++;
                if (it.in_last) begin
                    word = (grp_fill == 1) ? {grp_bits[7:0], 16'h0000}
                                           : {grp_bits[15:0], 8'h00};
                    push_result(CHARSET[word[23:18]], 1'b0, 1'b0);
                    push_result(CHARSET[word[17:12]], 1'b0, 1'b0);
                    push_result((grp_fill == 1) ? PAD_CHAR : CHARSET[word[11:6]],
                                1'b0, 1'b0);
                    push_result(PAD_CHAR, 1'b1, 1'b0);
                    clear_group();
                end
            end
        end else begin
            sx = sextet_index(it.in_byte);
            if (it.in_byte != PAD_CHAR && sx < 0) begin
                push_result(8'h00, it.in_last, 1'b1);
                clear_group();
            end else if (it.in_byte != PAD_CHAR && grp_fill == 3) begin
                word = {grp_bits, sx[5:0]};
                push_result(word[23:16], 1'b0, 1'b0);
                push_result(word[15:8], 1'b0, 1'b0);
                push_result(word[7:0], it.in_last, 1'b0);
                clear_group();
            end else begin
                if (it.in_byte == PAD_CHAR) begin
                    if (pad_seen < 3) pad_seen++;
                end else begin
                    grp_bits = {grp_bits[11:0], sx[5:0]};
                    grp_fill++;
                end
                if (it.in_last) begin
                    case (grp_fill)
                        1: push_result(8'h00, 1'b1, 1'b1);
                        2: push_result(grp_bits[11:4], 1'b1, 1'b0);
                        3: begin
                            push_result(grp_bits[17:10], 1'b0, 1'b0);
                            push_result(grp_bits[9:2], 1'b1, 1'b0);
                        end
                        default: ;
                    endcase
                    clear_group();
                end
            end
        end
    endfunction

    always @(posedge aclk) begin : byte_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                codec_step(s_data);
            end
            if (s_gap != 0) begin
                s_gap--;
                s_valid <= 1'b0;
            end else if (byte_q.size() != 0) begin
                s_data  <= byte_q.pop_front();
                s_valid <= 1'b1;
                if ($urandom_range(0, 23) == 0) s_burst = !s_burst;
                s_gap = s_burst ? 0 : $urandom_range(0, 7);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : result_sink
        b64c_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("unexpected result: byte %02h last %0b bad %0b",
                                 m_data.out_byte, m_data.out_last, m_data.bad_char);
                end else begin
                    want = expected_q.pop_front();
                    if (m_data.out_byte !== want.out_byte ||
                        m_data.out_last !== want.out_last ||
                        m_data.bad_char !== want.bad_char) begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS)
                            $display({"mismatch: expected byte %02h last %0b bad %0b,",
                                      " got byte %02h last %0b bad %0b"},
                                     want.out_byte, want.out_last, want.bad_char,
                                     m_data.out_byte, m_data.out_last,
                                     m_data.bad_char);
                    end
                end
                if ($urandom_range(0, 23) == 0) m_burst = !m_burst;
                m_hold = m_burst ? 0 : $urandom_range(0, 7);
            end
            if (m_hold != 0) begin
                m_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("base64_codec_custom_alphabet_top_tb: done, errors");
            $finish;
        end
    end

    task automatic add_item(input logic [7:0] val, input logic last);
        b64c_in_t it;
        it.in_byte = val;
        it.in_last = last;
        byte_q.push_back(it);
    endtask

    // Wait until everything has been sent and checked, then let the pipe drain.
    task automatic wait_idle();
        do @(posedge aclk);
        while (s_valid || byte_q.size() != 0 || expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_direction(input bit dir);
        @(posedge aclk);
        cfg_data  <= dir;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        codec_dir = dir;
        clear_group();
    endtask

    task automatic add_byte_message(output int count);
        int len;
        bit open;
        len   = $urandom_range(1, 10);
        open  = ($urandom_range(0, 7) == 0);
        count = len;
        for (int i = 0; i < len; i++)
            add_item(8'($urandom_range(0, 255)), (i == len - 1) && !open);
    endtask

    // Mostly well-formed character groups with padding; some get corrupted.
    task automatic add_char_message(output int count);
        logic [7:0] chars[$];
        int         groups;
        int         tail;
        int         pos;
        bit         open;
        groups = $urandom_range(0, 3);
        tail   = $urandom_range(0, 3);
        open   = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < groups * 4 + tail; i++)
            chars.push_back(CHARSET[$urandom_range(0, 63)]);
        if (tail != 0) begin
            for (int i = tail; i < 4; i++) chars.push_back(PAD_CHAR);
        end
        if (chars.size() == 0) chars.push_back(CHARSET[$urandom_range(0, 63)]);
        if ($urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, chars.size() - 1);
            chars[pos] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 7) == 0) begin
            pos = $urandom_range(0, chars.size());
            chars.insert(pos, PAD_CHAR);
        end
        if ($urandom_range(0, 7) == 0) void'(chars.pop_back());
        if (chars.size() == 0) chars.push_back(8'($urandom_range(0, 255)));
        count = chars.size();
        for (int i = 0; i < chars.size(); i++)
            add_item(chars[i], (i == chars.size() - 1) && !open);
    endtask

    initial begin : stimulus
        int sent;
        int n;
        codec_dir = DIR_ENCODE;
        clear_group();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Encode at reset direction: one-byte tail, two-byte tail, full group,
        // then a partial group that the next direction write must discard.
        add_item(8'h00, 1'b1);
        add_item(8'hFF, 1'b0);
        add_item(8'hFF, 1'b1);
        add_item(8'h12, 1'b0);
        add_item(8'h34, 1'b0);
        add_item(8'h56, 1'b0);
        add_item(8'hAB, 1'b0);
        add_item(8'hCD, 1'b0);
        wait_idle();

        set_direction(DIR_DECODE);
        // Padding inside a group, then a dangling single sextet
        add_item(CHARSET[0], 1'b0);
        add_item(CHARSET[63], 1'b0);
        add_item(PAD_CHAR, 1'b0);
        add_item(CHARSET[21], 1'b0);
        add_item(CHARSET[42], 1'b0);
        add_item(CHARSET[7], 1'b1);
        // Three- and two-character tails
        add_item(CHARSET[63], 1'b0);
        add_item(CHARSET[63], 1'b0);
        add_item(CHARSET[63], 1'b1);
        add_item(CHARSET[1], 1'b0);
        add_item(CHARSET[2], 1'b1);
        // Bad character mid-message, then a tail of padding on an empty group
        add_item(CHARSET[5], 1'b0);
        add_item(8'h00, 1'b0);
        add_item(PAD_CHAR, 1'b1);
        // Saturating padding run ending on a bad character
        repeat (4) add_item(PAD_CHAR, 1'b0);
        add_item(8'hFF, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            set_direction((ph % 2 == 0) ? DIR_ENCODE : DIR_DECODE);
            sent = 0;
            while (sent < 40) begin
                if (codec_dir == DIR_ENCODE) add_byte_message(n);
                else add_char_message(n);
                sent += n;
            end
            wait_idle();
        end

        if (fault_count == 0)
            $display("base64_codec_custom_alphabet_top_tb: done, clean");
        else
            $display("base64_codec_custom_alphabet_top_tb: done, errors");
        $finish;
    end

endmodule
